// ----- design/tbdetok_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbdetok_pkg
// Shared types, result kinds and the keyword ROM of the detokenizer.
// ----------------------------------------------------------------------------
package tbdetok_pkg;

    // Result kinds
    typedef enum logic [2:0] {
        K_LENGTH = 3'd0,
        K_HEADER = 3'd1,
        K_CHAR   = 3'd2,
        K_EOL    = 3'd3,
        K_EOP    = 3'd4,
        K_EXTRA  = 3'd5
    } t_kind;

    localparam int unsigned TEXT_BYTES = 13;            // "{Token 0xHH} "
    localparam int unsigned POS_W      = $clog2(TEXT_BYTES);
    localparam logic [7:0]  LAST_KEYWORD = 8'hEA;
    localparam logic [6:0]  SPACE_CHAR   = 7'h20;

    typedef logic [8*TEXT_BYTES-1:0] t_text;
    typedef logic [POS_W-1:0]        t_pos;

    // Controller -> datapath
    typedef struct packed {
        logic  hold_low;    // latch byte as low half of a word
        logic  hold_link;   // latch {byte, low} as line link
        logic  emit;        // load output register from the input byte
        t_kind kind;
        logic  char_space;  // char result is a space, not the byte
        logic  last;
        logic  load_text;   // load token text for expansion
        logic  emit_text;   // emit next token text char
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;
        logic link_zero;
        logic text_last;
        logic byte_zero;
        logic byte_token;
        logic file_start;
    } t_stat;

    // Keyword text, right-justified, zero padded on the left
    function automatic logic [63:0] kw_word(input logic [6:0] idx);
        logic [63:0] w;
        unique case (idx)
            7'd0:   w = "END ";      7'd1:   w = "FOR ";
            7'd2:   w = "NEXT ";     7'd3:   w = "DATA ";
            7'd4:   w = "INPUT ";    7'd5:   w = " DEL ";
            7'd6:   w = "DIM ";      7'd7:   w = "READ ";
            7'd8:   w = "GR ";       7'd9:   w = "TEXT ";
            7'd10:  w = "PR# ";      7'd11:  w = "IN# ";
            7'd12:  w = "CALL ";     7'd13:  w = "PLOT ";
            7'd14:  w = "HLIN ";     7'd15:  w = "VLIN ";
            7'd16:  w = "HGR2 ";     7'd17:  w = "HGR ";
            7'd18:  w = "HCOLOR= ";  7'd19:  w = "HPLOT ";
            7'd20:  w = "DRAW ";     7'd21:  w = "XDRAW ";
            7'd22:  w = "HTAB ";     7'd23:  w = "HOME ";
            7'd24:  w = "ROT= ";     7'd25:  w = "SCALE= ";
            7'd26:  w = "SHLOAD ";   7'd27:  w = "TRACE ";
            7'd28:  w = "NOTRACE ";  7'd29:  w = "NORMAL ";
            7'd30:  w = "INVERSE ";  7'd31:  w = "FLASH ";
            7'd32:  w = "COLOR= ";   7'd33:  w = "POP ";
            7'd34:  w = "VTAB ";     7'd35:  w = "HIMEM: ";
            7'd36:  w = "LOMEM: ";   7'd37:  w = "ONERR ";
            7'd38:  w = "RESUME ";   7'd39:  w = "RECALL ";
            7'd40:  w = "STORE ";    7'd41:  w = "SPEED= ";
            7'd42:  w = "LET ";      7'd43:  w = "GOTO ";
            7'd44:  w = "RUN ";      7'd45:  w = "IF ";
            7'd46:  w = "RESTORE ";  7'd47:  w = "& ";
            7'd48:  w = "GOSUB ";    7'd49:  w = "RETURN ";
            7'd50:  w = "REM ";      7'd51:  w = "STOP ";
            7'd52:  w = "ON ";       7'd53:  w = "WAIT ";
            7'd54:  w = "LOAD ";     7'd55:  w = "SAVE ";
            7'd56:  w = "DEF ";      7'd57:  w = "POKE ";
            7'd58:  w = "PRINT ";    7'd59:  w = "CONT ";
            7'd60:  w = "LIST ";     7'd61:  w = "CLEAR ";
            7'd62:  w = "GET ";      7'd63:  w = "NEW ";
            7'd64:  w = "TAB ";      7'd65:  w = " TO ";
            7'd66:  w = "FN ";       7'd67:  w = "SPC( ";
            7'd68:  w = "THEN ";     7'd69:  w = " AT ";
            7'd70:  w = "NOT ";      7'd71:  w = " STEP ";
            7'd72:  w = "+ ";        7'd73:  w = "- ";
            7'd74:  w = "* ";        7'd75:  w = "/ ";
            7'd76:  w = "^ ";        7'd77:  w = " AND";
            7'd78:  w = " OR";       7'd79:  w = "> ";
            7'd80:  w = "= ";        7'd81:  w = "< ";
            7'd82:  w = "SGN ";      7'd83:  w = "INT ";
            7'd84:  w = "ABS ";      7'd85:  w = "USR ";
            7'd86:  w = "FRE ";      7'd87:  w = "SCRN ( ";
            7'd88:  w = "PDL ";      7'd89:  w = "POS ";
            7'd90:  w = "SQR ";      7'd91:  w = "RND ";
            7'd92:  w = "LOG ";      7'd93:  w = "EXP ";
            7'd94:  w = "COS ";      7'd95:  w = "SIN ";
            7'd96:  w = "TAN ";      7'd97:  w = "ATN ";
            7'd98:  w = "PEEK ";     7'd99:  w = "LEN ";
            7'd100: w = "STR$ ";     7'd101: w = "VAL ";
            7'd102: w = "ASC ";      7'd103: w = "CHR$ ";
            7'd104: w = "LEFT$ ";    7'd105: w = "RIGHT$ ";
            7'd106: w = "MID$ ";
            default: w = '0;
        endcase
        return w;
    endfunction

    // Index of the highest nonzero byte (first char of the keyword)
    function automatic logic [2:0] kw_top(input logic [63:0] w);
        logic [2:0] top;
        top = '0;
        for (int i = 0; i < 8; i++) begin
            if (w[8*i +: 8] != 8'h00) begin
                top = 3'(i);
            end
        end
        return top;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'h0, nib};
        end else begin
            c = 8'h37 + {4'h0, nib};
        end
        return c;
    endfunction

endpackage

// ----- design/tbdetok_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbdetok_in_if
// Input channel: one file byte per item.
// ----------------------------------------------------------------------------
interface tbdetok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_start;

    modport source (output valid, data_byte, file_start, input ready);
    modport sink   (input valid, data_byte, file_start, output ready);
endinterface

// ----- design/tbdetok_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbdetok_out_if
// Output channel: one listing result per item.
// ----------------------------------------------------------------------------
interface tbdetok_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] word_value;
    logic [15:0] line_number;
    logic [6:0]  char_code;
    logic        last_of_run;

    modport source (output valid, kind, word_value, line_number, char_code, last_of_run,
                    input ready);
    modport sink   (input valid, kind, word_value, line_number, char_code, last_of_run,
                    output ready);
endinterface

// ----- design/tbdetok_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbdetok_ctrl
// Parse state machine: file framing and token expansion sequencing.
// ----------------------------------------------------------------------------
module tbdetok_ctrl
    import tbdetok_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_LEN_LO,
        ST_LEN_HI,
        ST_LINK_LO,
        ST_LINK_HI,
        ST_NUM_LO,
        ST_NUM_HI,
        ST_BODY,
        ST_EXTRA,
        ST_TEXT
    } t_state;

    t_state r_state, n_state;
    t_state phase;

    assign o_in_ready = (r_state != ST_TEXT) && i_stat.out_free;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.kind = K_CHAR;
        // a restart byte is always the length low byte
        phase = i_stat.file_start ? ST_LEN_LO : r_state;
        if (r_state == ST_TEXT) begin
            if (i_stat.out_free) begin
                o_cmd.emit_text = 1'b1;
                if (i_stat.text_last) begin
                    n_state = ST_BODY;
                end
            end
        end else if (i_in_valid && o_in_ready) begin
            unique case (phase)
                ST_LEN_LO: begin
                    o_cmd.hold_low = 1'b1;
                    n_state = ST_LEN_HI;
                end
                ST_LINK_LO: begin
                    o_cmd.hold_low = 1'b1;
                    n_state = ST_LINK_HI;
                end
                ST_NUM_LO: begin
                    o_cmd.hold_low = 1'b1;
                    n_state = ST_NUM_HI;
                end
                ST_LEN_HI: begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_LENGTH;
                    o_cmd.last = 1'b1;
                    n_state = ST_LINK_LO;
                end
                ST_LINK_HI: begin
                    o_cmd.hold_link = 1'b1;
                    n_state = ST_NUM_LO;
                end
                ST_NUM_HI: begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    if (i_stat.link_zero) begin
                        o_cmd.kind = K_EOP;
                        n_state = ST_EXTRA;
                    end else begin
                        o_cmd.kind = K_HEADER;
                        n_state = ST_BODY;
                    end
                end
                ST_BODY: begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.byte_zero) begin
                        o_cmd.kind = K_EOL;
                        o_cmd.last = 1'b1;
                        n_state = ST_LINK_LO;
                    end else if (i_stat.byte_token) begin
                        // leading space now, token text follows
                        o_cmd.kind = K_CHAR;
                        o_cmd.char_space = 1'b1;
                        o_cmd.load_text = 1'b1;
                        n_state = ST_TEXT;
                    end else begin
                        o_cmd.kind = K_CHAR;
                        o_cmd.last = 1'b1;
                    end
                end
                default: begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_EXTRA;
                    o_cmd.last = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LEN_LO;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/tbdetok_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbdetok_dp
// Datapath: word assembly, token text register and output register.
// ----------------------------------------------------------------------------
module tbdetok_dp
    import tbdetok_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [2:0]  o_kind,
    output logic [15:0] o_word_value,
    output logic [15:0] o_line_number,
    output logic [6:0]  o_char_code,
    output logic        o_last_of_run
);

    logic [7:0]  r_low;
    logic [15:0] r_link;
    t_text       r_text, n_text;
    t_pos        r_pos,  n_pos;

    logic        r_valid;
    t_kind       r_kind,  n_kind;
    logic [15:0] r_word,  n_word;
    logic [15:0] r_num,   n_num;
    logic [6:0]  r_char,  n_char;
    logic        r_last,  n_last;

    logic [63:0] kw;
    logic [15:0] full_word;
    logic        load_out;

    assign kw        = kw_word(i_data_byte[6:0]);
    assign full_word = {i_data_byte, r_low};
    assign load_out  = i_cmd.emit || i_cmd.emit_text;

    assign o_stat.out_free   = !r_valid || i_out_ready;
    assign o_stat.link_zero  = (r_link == 16'h0000);
    assign o_stat.text_last  = (r_pos == '0);
    assign o_stat.byte_zero  = (i_data_byte == 8'h00);
    assign o_stat.byte_token = i_data_byte[7];
    assign o_stat.file_start = i_file_start;

    // token text: keyword from ROM or the unassigned-token form
    always_comb begin
        if (i_data_byte <= LAST_KEYWORD) begin
            n_text = {{(8*TEXT_BYTES-64){1'b0}}, kw};
            n_pos  = t_pos'(kw_top(kw));
        end else begin
            n_text = {"{Token 0x", hex_char(i_data_byte[7:4]),
                      hex_char(i_data_byte[3:0]), "} "};
            n_pos  = t_pos'(TEXT_BYTES - 1);
        end
    end

    // result payload
    always_comb begin
        n_kind = i_cmd.kind;
        n_word = '0;
        n_num  = '0;
        n_char = '0;
        n_last = i_cmd.last;
        if (i_cmd.emit_text) begin
            n_kind = K_CHAR;
            n_char = r_text[{r_pos, 3'b000} +: 7];
            n_last = (r_pos == '0);
        end else begin
            unique case (i_cmd.kind)
                K_LENGTH: n_word = full_word;
                K_HEADER: begin
                    n_word = r_link;
                    n_num  = full_word;
                end
                K_CHAR:   n_char = i_cmd.char_space ? SPACE_CHAR : i_data_byte[6:0];
                K_EXTRA:  n_word = {8'h00, i_data_byte};
                default:  n_word = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load_out) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_low) begin
            r_low <= i_data_byte;
        end
        if (i_cmd.hold_link) begin
            r_link <= full_word;
        end
        if (i_cmd.load_text) begin
            r_text <= n_text;
            r_pos  <= n_pos;
        end else if (i_cmd.emit_text) begin
            r_pos  <= r_pos - t_pos'(1);
        end
        if (load_out) begin
            r_kind <= n_kind;
            r_word <= n_word;
            r_num  <= n_num;
            r_char <= n_char;
            r_last <= n_last;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_kind        = r_kind;
    assign o_word_value  = r_word;
    assign o_line_number = r_num;
    assign o_char_code   = r_char;
    assign o_last_of_run = r_last;

endmodule

// ----- design/tokenized_basic_detokenizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tokenized_basic_detokenizer_core
// Byte-serial detokenizer for tokenized BASIC program files.
// ----------------------------------------------------------------------------
// Feed the file one byte per input item, with file_start set on its first
// byte. The block reports the length word, one header per line (link and
// line number), the listing text one character per result item, an end of
// line per zero byte, an end of program at the zero link, and then every
// further byte as an extra byte. last_of_run marks the final result of each
// input byte; bytes that only complete half a word, and the link high byte,
// give no result. A token byte gives a space and then the keyword text, or
// the unassigned-token form; the text leaves through the single output
// register one character per cycle while the output is not stalled, and no
// new byte is taken until the last character is loaded. The output register
// is one deep, so input is taken while a result waits only if that result is
// taken in the same cycle.
// ----------------------------------------------------------------------------
module tokenized_basic_detokenizer_core
    import tbdetok_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    tbdetok_in_if.sink   i_in,
    tbdetok_out_if.source o_out
);

    // control / status between the state machine and the datapath
    t_cmd  cmd;
    t_stat stat;

    tbdetok_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // words, token text and the output register
    tbdetok_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_in.data_byte),
        .i_file_start  (i_in.file_start),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_kind        (o_out.kind),
        .o_word_value  (o_out.word_value),
        .o_line_number (o_out.line_number),
        .o_char_code   (o_out.char_code),
        .o_last_of_run (o_out.last_of_run)
    );

endmodule

// ----- design/tbdetok_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbdetok_checker
// Port-level assertions for the detokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module tbdetok_checker
    import tbdetok_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_kind,
    input logic [15:0] i_word_value,
    input logic [15:0] i_line_number,
    input logic [6:0]  i_char_code,
    input logic        i_last_of_run
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
            && $stable(i_word_value) && $stable(i_line_number)
            && $stable(i_char_code) && $stable(i_last_of_run))
        else $error("result changed while stalled");

    // no byte is taken while a result sits blocked
    a_no_accept_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !(i_in_valid && i_in_ready))
        else $error("byte accepted with blocked output");

    // only token expansion gives several results per byte
    a_multi_is_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last_of_run |-> i_kind == K_CHAR)
        else $error("non-final result that is not a character");

    // line number only travels with a header
    a_num_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != K_HEADER |-> i_line_number == 16'h0000)
        else $error("line number outside a header");

endmodule

bind tokenized_basic_detokenizer_core tbdetok_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_kind        (o_out.kind),
    .i_word_value  (o_out.word_value),
    .i_line_number (o_out.line_number),
    .i_char_code   (o_out.char_code),
    .i_last_of_run (o_out.last_of_run)
);
